[hdl/pdu_pkg.sv]
// Shared types and constants for the percent decoder with UTF-8 repair.
// Used by pdu_core and percent_decoder_utf8_repair; depends on nothing else.
package pdu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_present;
    logic       end_of_text;
    logic       text_valid;
  } out_item_t;

  // Control state of the decoder and repair stage. The held bytes live apart.
  typedef struct packed {
    logic [1:0] escape_phase;
    logic [7:0] hex_accum;
    logic [1:0] continuations_left;
    logic [1:0] held_count;
    logic       seen_invalid;
    logic       output_stopped;
  } pdu_state_t;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned ResIdxW    = 3;

  localparam logic [1:0] PhaseIdle  = 2'd0;
  localparam logic [1:0] PhaseFirst = 2'd1;
  localparam logic [1:0] PhaseSecond = 2'd2;

  localparam logic [7:0] ReplByte0   = 8'hEF;
  localparam logic [7:0] ReplByte1   = 8'hBF;
  localparam logic [7:0] ReplByte2   = 8'hBD;
  localparam logic [7:0] StrayPrefix = 8'hC2;
  localparam logic [7:0] LeadMax     = 8'hF7;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead4Min    = 8'hF0;
  localparam logic [7:0] LeadMin     = 8'hC0;
  localparam logic [7:0] ContMin     = 8'h80;
  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;

endpackage

[hdl/pdu_core.sv]
// Per-word step logic: escape decoding, UTF-8 repair and the end marker.
// Purely combinational; builds the list of results for one word. Uses pdu_pkg.
module pdu_core import pdu_pkg::*; (
  input  in_item_t              item,
  input  pdu_state_t            state,
  input  logic [2:0][7:0]       held,
  output pdu_state_t            state_next,
  output logic [2:0][7:0]       held_next,
  output out_item_t             res [MaxResults],
  output logic [ResIdxW-1:0]    res_count
);

  // Strict check on the lead byte and the first continuation.
  function automatic logic strict_ok(input logic [7:0] lead, input logic [7:0] b1);
    logic ok;
    begin
      if (lead < 8'hC2)        ok = 1'b0;
      else if (lead < 8'hE0)   ok = 1'b1;
      else if (lead == 8'hE0)  ok = (b1 >= 8'hA0);
      else if (lead == 8'hED)  ok = (b1 <= 8'h9F);
      else if (lead < 8'hF0)   ok = 1'b1;
      else if (lead == 8'hF0)  ok = (b1 >= 8'h90);
      else if (lead < 8'hF4)   ok = 1'b1;
      else if (lead == 8'hF4)  ok = (b1 <= 8'h8F);
      else                     ok = 1'b0;
      return ok;
    end
  endfunction

  function automatic out_item_t text_item(input logic [7:0] b);
    out_item_t r;
    begin
      r.out_byte    = b;
      r.out_present = 1'b1;
      r.end_of_text = 1'b0;
      r.text_valid  = 1'b0;
      return r;
    end
  endfunction

  logic [7:0] b;
  logic       digit_ok;
  logic [3:0] digit;
  logic [7:0] hex_shifted;

  assign b = item.in_byte;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39)      digit = 4'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) digit = 4'(b - 8'h37);
    else if (b >= 8'h61 && b <= 8'h66) digit = 4'(b - 8'h57);
    else                               digit_ok = 1'b0;
  end

  assign hex_shifted = {state.hex_accum[3:0], digit};

  always_comb begin
    pdu_state_t      s;
    logic [2:0][7:0] h;
    logic            rep_en;
    logic [7:0]      c;
    logic [7:0]      b1;
    logic [ResIdxW-1:0] n;
    s      = state;
    h      = held;
    rep_en = 1'b0;
    c      = b;
    b1     = 8'd0;
    n      = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end

    // Escape decoding.
    if (item.byte_present && !state.output_stopped) begin
      if (b == 8'd0) begin
        s.output_stopped     = 1'b1;
        s.escape_phase       = PhaseIdle;
        s.hex_accum          = 8'd0;
        s.held_count         = 2'd0;
        s.continuations_left = 2'd0;
      end else if (state.escape_phase != PhaseIdle) begin
        if (!digit_ok) begin
          s.escape_phase = PhaseIdle;
          s.hex_accum    = 8'd0;
          rep_en         = (b > AsciiMax);
        end else if (state.escape_phase == PhaseFirst) begin
          s.escape_phase = PhaseSecond;
          s.hex_accum    = hex_shifted;
        end else begin
          s.escape_phase = PhaseIdle;
          s.hex_accum    = 8'd0;
          rep_en         = 1'b1;
          c              = hex_shifted;
        end
      end else if (b == CharPercent) begin
        s.escape_phase = PhaseFirst;
      end else if (b == CharPlus) begin
        rep_en = 1'b1;
        c      = CharSpace;
      end else begin
        rep_en = 1'b1;
      end
    end

    // UTF-8 repair.
    if (rep_en) begin
      if (state.continuations_left != 2'd0) begin
        if ((c & LeadMin) == ContMin) begin
          if (state.continuations_left == 2'd1) begin
            b1 = (state.held_count >= 2'd2) ? held[1] : c;
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < state.held_count) begin
                res[n] = text_item(held[i]);
                n      = n + 1'b1;
              end
            end
            res[n] = text_item(c);
            n      = n + 1'b1;
            if (!strict_ok(held[0], b1)) s.seen_invalid = 1'b1;
            s.held_count         = 2'd0;
            s.continuations_left = 2'd0;
          end else begin
            if (state.held_count != 2'd3) h[state.held_count] = c;
            s.held_count         = state.held_count + 2'd1;
            s.continuations_left = state.continuations_left - 2'd1;
          end
        end else begin
          res[0] = text_item(ReplByte0);
          res[1] = text_item(ReplByte1);
          res[2] = text_item(ReplByte2);
          n      = 3'd3;
          s.held_count         = 2'd0;
          s.continuations_left = 2'd0;
        end
      end else if (c == 8'd0) begin
        s.output_stopped = 1'b1;
      end else if (c < ContMin) begin
        res[0] = text_item(c);
        n      = 3'd1;
      end else if (c < LeadMin) begin
        res[0] = text_item(StrayPrefix);
        res[1] = text_item(c);
        n      = 3'd2;
      end else if (c <= LeadMax) begin
        h[0]         = c;
        s.held_count = 2'd1;
        if (c < Lead3Min)      s.continuations_left = 2'd1;
        else if (c < Lead4Min) s.continuations_left = 2'd2;
        else                   s.continuations_left = 2'd3;
      end
    end

    // The last word closes the string and returns the state to idle.
    if (item.is_last) begin
      res[n].out_byte    = 8'd0;
      res[n].out_present = 1'b0;
      res[n].end_of_text = 1'b1;
      res[n].text_valid  = !s.seen_invalid;
      n = n + 1'b1;
      s = '0;
    end

    state_next = s;
    held_next  = h;
    res_count  = n;
  end

endmodule

[hdl/percent_decoder_utf8_repair.sv]
// Percent decoder with UTF-8 repair: one escaped byte per input word, decoded text out.
// Latency: the first result of a word is offered the cycle after the word is accepted.
// Throughput: one word per cycle while each word gives at most one result and rsp_stall
// is low; results drain one per unstalled cycle, and the next word enters as the last leaves.
// Reset (rst, synchronous) clears the escape, repair and output-list state.
// Uses pdu_pkg and pdu_core.
module percent_decoder_utf8_repair import pdu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req_word,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp_word
);

  pdu_state_t         state;
  pdu_state_t         state_next;
  logic [2:0][7:0]    held;
  logic [2:0][7:0]    held_next;
  out_item_t          res_list [MaxResults];
  logic [ResIdxW-1:0] res_list_count;

  out_item_t          res_q [MaxResults];
  logic [ResIdxW-1:0] res_cnt;
  logic [ResIdxW-1:0] res_idx;
  logic               accept;
  logic               take;
  logic               last_pending;

  pdu_core u_core (
    .item       (req_word),
    .state      (state),
    .held       (held),
    .state_next (state_next),
    .held_next  (held_next),
    .res        (res_list),
    .res_count  (res_list_count)
  );

  assign rsp_valid    = (res_idx != res_cnt);
  assign rsp_word     = res_q[res_idx];
  assign take         = rsp_valid && !rsp_stall;
  assign last_pending = ((res_idx + 1'b1) == res_cnt);
  // A new word may enter when the list is empty or its final entry leaves now.
  assign req_stall    = rsp_valid && !(last_pending && !rsp_stall);
  assign accept       = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= '0;
      res_cnt <= '0;
      res_idx <= '0;
    end else if (accept) begin
      state   <= state_next;
      res_cnt <= res_list_count;
      res_idx <= '0;
    end else if (take) begin
      res_idx <= res_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_list[i];
      end
    end
  end

endmodule

[test/tb_percent_decoder_utf8_repair.sv]
// Testbench for percent_decoder_utf8_repair: escaped strings in, decoded UTF-8 words out.
// It predicts every result word in a model of its own and checks the words in order.
// Depends on pdu_pkg and the percent_decoder_utf8_repair RTL.
`timescale 1ns / 100ps

module tb_percent_decoder_utf8_repair;
  import pdu_pkg::*;

  // Bounds of the strict UTF-8 rules: no overlong forms, no surrogates, nothing past U+10FFFF.
  localparam logic [7:0] MinTwoByteLead = 8'hC2;
  localparam logic [7:0] SurrogateLead  = 8'hED;
  localparam logic [7:0] Lead4Max       = 8'hF4;
  localparam logic [7:0] E0SecondMin    = 8'hA0;
  localparam logic [7:0] EdSecondMax    = 8'h9F;
  localparam logic [7:0] F0SecondMin    = 8'h90;
  localparam logic [7:0] F4SecondMax    = 8'h8F;
  localparam int StallLimit = 2000;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req_word;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp_word;

  // Predictor state for the string in flight.
  logic [1:0] esc_phase;
  logic [7:0] hex_acc;
  logic [1:0] conts_left;
  logic [7:0] held_seq [3];
  logic [1:0] held_n;
  logic       bad_seen;
  logic       text_stopped;

  out_item_t pending_text [$];
  out_item_t text_want;
  in_item_t  string_words [$];
  int        words_sent = 0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        src_idle_odds = 0;
  int        sink_idle_odds = 0;
  int        sink_stall_left = 0;

  percent_decoder_utf8_repair i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - 8'h30;
    if (b >= "A" && b <= "F") return int'(b) - 8'h41 + 10;
    if (b >= "a" && b <= "f") return int'(b) - 8'h61 + 10;
    return -1;
  endfunction

  function automatic bit strict_lead_ok(input logic [7:0] lead, input logic [7:0] second);
    if (lead < MinTwoByteLead) return 1'b0;
    if (lead < Lead3Min) return 1'b1;
    if (lead == Lead3Min) return second >= E0SecondMin;
    if (lead == SurrogateLead) return second <= EdSecondMax;
    if (lead < Lead4Min) return 1'b1;
    if (lead == Lead4Min) return second >= F0SecondMin;
    if (lead < Lead4Max) return 1'b1;
    if (lead == Lead4Max) return second <= F4SecondMax;
    return 1'b0;
  endfunction

  task automatic clear_decoder_state();
    esc_phase    = PhaseIdle;
    hex_acc      = 8'h00;
    conts_left   = 2'd0;
    held_n       = 2'd0;
    bad_seen     = 1'b0;
    text_stopped = 1'b0;
  endtask

  task automatic queue_text_byte(input logic [7:0] b);
    out_item_t r;
    r.out_byte    = b;
    r.out_present = 1'b1;
    r.end_of_text = 1'b0;
    r.text_valid  = 1'b0;
    pending_text.push_back(r);
  endtask

  task automatic repair_byte(input logic [7:0] c);
    logic [7:0] second;
    int i;
    if (text_stopped) return;
    if (conts_left != 2'd0) begin
      if (c[7:6] == ContMin[7:6]) begin
        if (conts_left == 2'd1) begin
          second = (held_n >= 2'd2) ? held_seq[1] : c;
          for (i = 0; i < int'(held_n); i++) queue_text_byte(held_seq[i]);
          queue_text_byte(c);
          if (!strict_lead_ok(held_seq[0], second)) bad_seen = 1'b1;
          held_n     = 2'd0;
          conts_left = 2'd0;
        end else begin
          held_seq[held_n] = c;
          held_n     = held_n + 2'd1;
          conts_left = conts_left - 2'd1;
        end
      end else begin
        // A broken sequence becomes U+FFFD and the breaking byte is lost.
        queue_text_byte(ReplByte0);
        queue_text_byte(ReplByte1);
        queue_text_byte(ReplByte2);
        held_n     = 2'd0;
        conts_left = 2'd0;
      end
      return;
    end
    if (c == 8'h00) begin
      text_stopped = 1'b1;
    end else if (c <= AsciiMax) begin
      queue_text_byte(c);
    end else if (c < LeadMin) begin
      queue_text_byte(StrayPrefix);
      queue_text_byte(c);
    end else if (c <= LeadMax) begin
      held_seq[0] = c;
      held_n      = 2'd1;
      conts_left  = (c < Lead3Min) ? 2'd1 : ((c < Lead4Min) ? 2'd2 : 2'd3);
    end
  endtask

  task automatic predict_text_for_word(input in_item_t w);
    int digit;
    logic [7:0] v;
    out_item_t r;
    if (w.byte_present && !text_stopped) begin
      if (w.in_byte == 8'h00) begin
        text_stopped = 1'b1;
        esc_phase    = PhaseIdle;
        hex_acc      = 8'h00;
        held_n       = 2'd0;
        conts_left   = 2'd0;
      end else if (esc_phase != PhaseIdle) begin
        digit = hex_value(w.in_byte);
        if (digit < 0) begin
          esc_phase = PhaseIdle;
          hex_acc   = 8'h00;
          if (w.in_byte > AsciiMax) repair_byte(w.in_byte);
        end else begin
          hex_acc = {hex_acc[3:0], 4'(digit)};
          if (esc_phase == PhaseFirst) begin
            esc_phase = PhaseSecond;
          end else begin
            v         = hex_acc;
            esc_phase = PhaseIdle;
            hex_acc   = 8'h00;
            repair_byte(v);
          end
        end
      end else if (w.in_byte == CharPercent) begin
        esc_phase = PhaseFirst;
      end else if (w.in_byte == CharPlus) begin
        repair_byte(CharSpace);
      end else begin
        repair_byte(w.in_byte);
      end
    end
    if (w.is_last) begin
      r.out_byte    = 8'h00;
      r.out_present = 1'b0;
      r.end_of_text = 1'b1;
      r.text_valid  = !bad_seen;
      pending_text.push_back(r);
      clear_decoder_state();
    end
  endtask

  // Offers one word, holds it until accepted, then predicts its results.
  task automatic send_word(input in_item_t w);
    @(negedge clk);
    if (src_idle_odds != 0 && $urandom_range(src_idle_odds, 1) == 1) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_text_for_word(w);
    if (w.byte_present) words_sent++;
  endtask

  task automatic send_text_byte(input logic [7:0] b, input bit last);
    in_item_t w;
    w.in_byte      = b;
    w.byte_present = 1'b1;
    w.is_last      = last;
    send_word(w);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    if ($urandom_range(1, 0) == 1) return 8'h41 + 8'(nib) - 8'd10;
    return 8'h61 + 8'(nib) - 8'd10;
  endfunction

  task automatic put_src(input logic [7:0] b);
    in_item_t w;
    w.in_byte      = b;
    w.byte_present = 1'b1;
    w.is_last      = 1'b0;
    string_words.push_back(w);
  endtask

  // Puts a decoded byte into the string, raw or as an escape.
  task automatic put_text_byte(input logic [7:0] b);
    if (b == CharPercent || b == CharPlus || $urandom_range(4, 0) == 0) begin
      put_src(CharPercent);
      put_src(hex_char(b[7:4]));
      put_src(hex_char(b[3:0]));
    end else begin
      put_src(b);
    end
  endtask

  task automatic add_token(input bit malformed);
    int kind;
    int conts;
    logic [7:0] lead;
    logic [7:0] b;
    in_item_t w;
    if (malformed) kind = $urandom_range(14, 0);
    else if ($urandom_range(9, 0) == 0) kind = $urandom_range(14, 9);
    else kind = $urandom_range(8, 0);
    case (kind)
      0, 1, 2, 3: put_text_byte(rand_byte(1, 127));
      4: put_src(CharPlus);
      5, 6: begin
        put_text_byte(rand_byte(8'hC2, 8'hDF));
        put_text_byte(rand_byte(8'h80, 8'hBF));
      end
      7: begin
        put_text_byte(rand_byte(8'hE0, 8'hEF));
        repeat (2) put_text_byte(rand_byte(8'h80, 8'hBF));
      end
      8: begin
        put_text_byte(rand_byte(8'hF0, 8'hF4));
        repeat (3) put_text_byte(rand_byte(8'h80, 8'hBF));
      end
      9: put_text_byte(rand_byte(8'h80, 8'hBF));
      10: begin
        lead  = rand_byte(8'hC0, 8'hF7);
        conts = (lead < Lead3Min) ? 0 : ((lead < Lead4Min) ? 1 : 2);
        put_text_byte(lead);
        repeat ($urandom_range(conts, 0)) put_text_byte(rand_byte(8'h80, 8'hBF));
        if ($urandom_range(1, 0) == 1) put_text_byte(rand_byte(1, 127));
        else put_text_byte(rand_byte(8'hC0, 8'hFF));
      end
      11: begin
        put_src(CharPercent);
        if ($urandom_range(1, 0) == 1) put_src(hex_char(4'($urandom_range(15, 0))));
        do b = rand_byte(1, 255); while (hex_value(b) >= 0);
        put_src(b);
      end
      12: put_src(rand_byte(1, 255));
      13: put_text_byte(rand_byte(8'hF8, 8'hFF));
      default: begin
        w.in_byte      = rand_byte(0, 255);
        w.byte_present = 1'b0;
        w.is_last      = 1'b0;
        string_words.push_back(w);
      end
    endcase
  endtask

  task automatic build_random_string(input bit malformed);
    int n;
    int zero_at;
    int i;
    in_item_t w;
    string_words.delete();
    n       = ($urandom_range(19, 0) == 0) ? 0 : int'($urandom_range(12, 1));
    zero_at = ($urandom_range(15, 0) == 0) ? int'($urandom_range(n, 0)) : -1;
    for (i = 0; i < n; i++) begin
      if (i == zero_at) begin
        case ($urandom_range(3, 0))
          0: put_src(8'h00);
          1: put_text_byte(8'h00);
          2: begin put_src(rand_byte(8'hC2, 8'hF4)); put_src(8'h00); end
          default: begin put_src(CharPercent); put_src(8'h00); end
        endcase
      end
      add_token(malformed);
    end
    // Sometimes leave an escape or a sequence open when the string ends.
    case ($urandom_range(7, 0))
      0: begin
        put_src(CharPercent);
        if ($urandom_range(1, 0) == 1) put_src(hex_char(4'($urandom_range(15, 0))));
      end
      1: put_text_byte(rand_byte(8'hC2, 8'hF4));
      default: ;
    endcase
    if (string_words.size() == 0 || $urandom_range(5, 0) == 0) begin
      w.in_byte      = rand_byte(0, 255);
      w.byte_present = 1'b0;
      w.is_last      = 1'b1;
      string_words.push_back(w);
    end else begin
      w = string_words.pop_back();
      w.is_last = 1'b1;
      string_words.push_back(w);
    end
  endtask

  task automatic send_random_strings(input bit malformed, input int target);
    int i;
    while (words_sent < target) begin
      build_random_string(malformed);
      for (i = 0; i < string_words.size(); i++) send_word(string_words[i]);
    end
  endtask

  task automatic test_escapes_and_special_bytes();
    in_item_t w;
    src_idle_odds  = 3;
    sink_idle_odds = 3;
    // A second percent breaks the escape, then "%4a", plus, a dropped lead, a stray byte.
    send_text_byte(CharPercent, 1'b0);
    send_text_byte(CharPercent, 1'b0);
    send_text_byte(CharPercent, 1'b0);
    send_text_byte("4", 1'b0);
    send_text_byte("a", 1'b0);
    send_text_byte(CharPlus, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h80, 1'b1);
    // An ASCII breaker is lost; a high breaker opens a two-byte sequence.
    send_text_byte(CharPercent, 1'b0);
    send_text_byte("G", 1'b0);
    send_text_byte(CharPercent, 1'b0);
    send_text_byte(8'hC3, 1'b0);
    send_text_byte(8'hA9, 1'b1);
    // Code point past U+10FFFF, a bad continuation, and a sequence cut by the end.
    send_text_byte(8'hF4, 1'b0);
    send_text_byte(8'h90, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'hC3, 1'b0);
    send_text_byte("A", 1'b0);
    send_text_byte(8'hE2, 1'b1);
    // A decoded zero stops the text.
    send_text_byte(CharPercent, 1'b0);
    send_text_byte("0", 1'b0);
    send_text_byte("0", 1'b0);
    send_text_byte("B", 1'b1);
    w.in_byte      = 8'hFF;
    w.byte_present = 1'b0;
    w.is_last      = 1'b1;
    send_word(w);
    send_text_byte("x", 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  task automatic test_wellformed_text();
    src_idle_odds  = 4;
    sink_idle_odds = 4;
    send_random_strings(1'b0, 230);
  endtask

  task automatic test_malformed_text();
    src_idle_odds  = 2;
    sink_idle_odds = 5;
    send_random_strings(1'b1, 350);
  endtask

  task automatic test_back_to_back_text();
    src_idle_odds  = 0;
    sink_idle_odds = 0;
    send_random_strings($urandom_range(1, 0) == 1, 430);
  endtask

  // Output side stalls in random bursts.
  always @(negedge clk) begin
    if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
      rsp_stall       <= 1'b1;
    end else if (sink_idle_odds != 0 && $urandom_range(sink_idle_odds, 1) == 1) begin
      sink_stall_left <= $urandom_range(9, 1) - 1;
      rsp_stall       <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result word %h arrived with nothing expected", $time, rsp_word);
      end else begin
        text_want = pending_text.pop_front();
        if (rsp_word.out_byte !== text_want.out_byte ||
            rsp_word.out_present !== text_want.out_present ||
            rsp_word.end_of_text !== text_want.end_of_text ||
            rsp_word.text_valid !== text_want.text_valid) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected byte %h present %b end %b valid %b, got %h %b %b %b",
                     $time, text_want.out_byte, text_want.out_present,
                     text_want.end_of_text, text_want.text_valid, rsp_word.out_byte,
                     rsp_word.out_present, rsp_word.end_of_text, rsp_word.text_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("percent_decoder_utf8_repair regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_word  = '0;
    clear_decoder_state();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_escapes_and_special_bytes();
    test_wellformed_text();
    test_malformed_text();
    test_back_to_back_text();
    @(negedge clk) req_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("percent_decoder_utf8_repair regression: pass");
    end else begin
      $display("percent_decoder_utf8_repair regression: fail");
    end
    $finish;
  end

endmodule

[percent_decoder_utf8_repair.f]
hdl/pdu_pkg.sv
hdl/pdu_core.sv
hdl/percent_decoder_utf8_repair.sv
test/tb_percent_decoder_utf8_repair.sv
